[rtl/gouraud_triangle_rasterizer_top_macros.svh]
// Assertion macros for the rasterizer
`ifndef GOURAUD_TRIANGLE_RASTERIZER_TOP_MACROS_SVH
`define GOURAUD_TRIANGLE_RASTERIZER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define GTR_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define GTR_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

[rtl/gtr_pkg.sv]
package gtr_pkg;
   localparam int ScreenWidthDef  = 1024;
   localparam int ScreenHeightDef = 512;
   localparam int ChannelBitsDef  = 5;
   localparam int XW   = 10;
   localparam int YW   = 9;
   localparam int CW   = 15;
   localparam int EW   = 22;  // edge weight, signed
   localparam int SW   = 28;  // weighted sum, signed
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic load;    // capture triangle
      logic setup;   // compute area / swap
      logic eval;    // compute edge weights of the current position
      logic div_go;  // start division of channel
      logic advance; // step the walk
   } cmd_type;

   typedef struct packed {
      logic walking;
      logic cov;
      logic div_done;
      logic last;
   } sts_type;
endpackage

[rtl/gouraud_triangle_rasterizer_top.sv]
// Gouraud triangle rasteriser. Pulse start with req_op low to load a triangle,
// then with req_op high once per box position; each accepted word yields one
// result word, on rsp_valid for exactly one cycle, which the receiver cannot
// stall. busy is high while a word is in work. A tick with no walk pending
// answers in the cycle it is taken. A load answers in S_OUT after S_SETUP, an
// uncovered tick in S_COV after S_EVAL (twice on the first tick of a walk, which
// seeds the position), a covered tick in S_OUT: each of the three channels takes
// a launch state and a 28-step restoring division of the weighted channel sum by
// the area in one shared divider, and that sets the pace.
`include "gouraud_triangle_rasterizer_top_macros.svh"
module gouraud_triangle_rasterizer_top
   import gtr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = ScreenWidthDef,
   parameter int SCREEN_HEIGHT = ScreenHeightDef,
   parameter int CHANNEL_BITS  = ChannelBitsDef
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_op,
   input  logic [XW-1:0] req_vertex_a_x,
   input  logic [YW-1:0] req_vertex_a_y,
   input  logic [XW-1:0] req_vertex_b_x,
   input  logic [YW-1:0] req_vertex_b_y,
   input  logic [XW-1:0] req_vertex_c_x,
   input  logic [YW-1:0] req_vertex_c_y,
   input  logic [CW-1:0] req_color_a,
   input  logic [CW-1:0] req_color_b,
   input  logic [CW-1:0] req_color_c,
   output logic          rsp_valid,
   output logic          rsp_covered,
   output logic [XW-1:0] rsp_pixel_x,
   output logic [YW-1:0] rsp_pixel_y,
   output logic [CW-1:0] rsp_pixel_color,
   output logic          rsp_done_res
);
   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] chan;
   logic       cov, pos;
   logic [XW-1:0] px;
   logic [YW-1:0] py;
   logic [CW-1:0] col;

   gtr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_op), .sts(sts),
      .cmd(cmd), .chan(chan), .busy(busy), .rsp_valid(rsp_valid),
      .rsp_covered(cov), .rsp_pos(pos), .rsp_done(rsp_done_res)
   );

   gtr_datapath #(
      .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .chan(chan), .sts(sts),
      .ax(req_vertex_a_x), .bx(req_vertex_b_x), .cx(req_vertex_c_x),
      .ay(req_vertex_a_y), .by(req_vertex_b_y), .cy(req_vertex_c_y),
      .ca(req_color_a), .cb(req_color_b), .cc(req_color_c),
      .px(px), .py(py), .color(col)
   );

   // drop position on words that carry none and colour on words that are not covered
   assign rsp_covered     = cov;
   assign rsp_pixel_x     = pos ? px : '0;
   assign rsp_pixel_y     = pos ? py : '0;
   assign rsp_pixel_color = cov ? col : '0;

   `GTR_ASSERT_IMPL(a_cov_needs_valid, clock, reset, rsp_covered, rsp_valid, "covered without valid")
   `GTR_ASSERT_IMPL(a_idle_word_is_tick, clock, reset, rsp_valid && !busy, start && req_op == OP_TICK, "idle result without tick")
   `GTR_ASSERT_NEXT(a_load_busy, clock, reset, start && !busy && req_op == OP_LOAD, busy, "load not taken")
endmodule

[rtl/gtr_div.sv]
module gtr_div
   import gtr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [SW-1:0] dividend, // non-negative
   input  logic [EW-1:0] divisor,  // positive
   output logic          done,
   output logic [SW-1:0] quot
);
   logic [SW-1:0] q_ff, q_in;
   logic [EW:0]   r_ff, r_in;
   logic [4:0]    n_ff, n_in;
   logic          run_ff, run_in;
   logic [EW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; run_in = run_ff;
      trial = {r_ff[EW-1:0], q_ff[SW-1]} - {1'b0, divisor};
      if (go) begin
         q_in = dividend; r_in = '0; n_in = 5'(SW - 1); run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[EW]) begin
            r_in = trial;
            q_in = {q_ff[SW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[EW-1:0], q_ff[SW-1]};
            q_in = {q_ff[SW-2:0], 1'b0};
         end
         n_in = n_ff - 5'd1;
         if (n_ff == '0) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   assign done = run_ff && (n_ff == '0);
   assign quot = q_in;
endmodule

[rtl/gtr_datapath.sv]
module gtr_datapath
   import gtr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = ScreenWidthDef,
   parameter int SCREEN_HEIGHT = ScreenHeightDef,
   parameter int CHANNEL_BITS  = ChannelBitsDef
)(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [1:0]    chan,
   output sts_type       sts,
   input  logic [XW-1:0] ax, bx, cx,
   input  logic [YW-1:0] ay, by, cy,
   input  logic [CW-1:0] ca, cb, cc,
   output logic [XW-1:0] px,
   output logic [YW-1:0] py,
   output logic [CW-1:0] color
);
   localparam logic [CHANNEL_BITS-1:0] ChMax = '1;
   logic [XW-1:0] x_ff [3];
   logic [YW-1:0] y_ff [3];
   logic [CW-1:0] c_ff [3];
   logic signed [EW-1:0] area_ff, w_ff [3];
   logic [XW-1:0] mnx_ff, mxx_ff, wx_ff;
   logic [YW-1:0] mny_ff, mxy_ff, wy_ff;
   logic [CW-1:0] col_ff;
   logic          walk_ff;
   logic signed [EW-1:0] area_raw, w_in [3];
   logic          pass [3];
   logic signed [SW-1:0] sum;
   logic [SW-1:0] quot;
   logic          ddone;

   function automatic logic [XW-1:0] satx(input logic [XW-1:0] v);
      return (32'(v) >= SCREEN_WIDTH) ? XW'(SCREEN_WIDTH - 1) : v;
   endfunction
   function automatic logic [YW-1:0] saty(input logic [YW-1:0] v);
      return (32'(v) >= SCREEN_HEIGHT) ? YW'(SCREEN_HEIGHT - 1) : v;
   endfunction
   function automatic logic signed [EW-1:0] edgef(
      input logic [XW-1:0] x0, input logic [YW-1:0] y0,
      input logic [XW-1:0] x1, input logic [YW-1:0] y1,
      input logic [XW-1:0] x2, input logic [YW-1:0] y2);
      logic signed [XW+1:0] dx2, dx1;
      logic signed [YW+1:0] dy1, dy2;
      dx2 = $signed({2'b0, x2}) - $signed({2'b0, x0});
      dy1 = $signed({2'b0, y1}) - $signed({2'b0, y0});
      dy2 = $signed({2'b0, y2}) - $signed({2'b0, y0});
      dx1 = $signed({2'b0, x1}) - $signed({2'b0, x0});
      return EW'(dx2) * EW'(dy1) - EW'(dy2) * EW'(dx1);
   endfunction
   function automatic logic topleft(input logic [XW-1:0] xi, input logic [YW-1:0] yi,
                                    input logic [XW-1:0] xj, input logic [YW-1:0] yj);
      return (yj > yi) || (yj == yi && xj > xi);
   endfunction

   assign area_raw = edgef(x_ff[0], y_ff[0], x_ff[1], y_ff[1], x_ff[2], y_ff[2]);
   assign w_in[0] = edgef(x_ff[1], y_ff[1], x_ff[2], y_ff[2], wx_ff, wy_ff);
   assign w_in[1] = edgef(x_ff[2], y_ff[2], x_ff[0], y_ff[0], wx_ff, wy_ff);
   assign w_in[2] = edgef(x_ff[0], y_ff[0], x_ff[1], y_ff[1], wx_ff, wy_ff);
   assign pass[0] = (w_ff[0] == 0) ? topleft(x_ff[1], y_ff[1], x_ff[2], y_ff[2])
                                   : (w_ff[0] > 0);
   assign pass[1] = (w_ff[1] == 0) ? topleft(x_ff[2], y_ff[2], x_ff[0], y_ff[0])
                                   : (w_ff[1] > 0);
   assign pass[2] = (w_ff[2] == 0) ? topleft(x_ff[0], y_ff[0], x_ff[1], y_ff[1])
                                   : (w_ff[2] > 0);

   always_comb begin
      logic [3*CHANNEL_BITS-1:0] sh0, sh1, sh2;
      sh0 = (3*CHANNEL_BITS)'(c_ff[0] >> (chan * CHANNEL_BITS));
      sh1 = (3*CHANNEL_BITS)'(c_ff[1] >> (chan * CHANNEL_BITS));
      sh2 = (3*CHANNEL_BITS)'(c_ff[2] >> (chan * CHANNEL_BITS));
      sum = SW'(w_ff[0]) * SW'($signed({1'b0, sh0[CHANNEL_BITS-1:0]}))
          + SW'(w_ff[1]) * SW'($signed({1'b0, sh1[CHANNEL_BITS-1:0]}))
          + SW'(w_ff[2]) * SW'($signed({1'b0, sh2[CHANNEL_BITS-1:0]}));
   end

   gtr_div u_div (
      .clock(clock), .reset(reset), .go(cmd.div_go), .dividend(sum),
      .divisor(area_ff), .done(ddone), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff[0] <= satx(ax); y_ff[0] <= saty(ay); c_ff[0] <= ca;
         x_ff[1] <= satx(bx); y_ff[1] <= saty(by); c_ff[1] <= cb;
         x_ff[2] <= satx(cx); y_ff[2] <= saty(cy); c_ff[2] <= cc;
      end
      if (cmd.setup) begin
         if (area_raw < 0) begin
            x_ff[1] <= x_ff[2]; x_ff[2] <= x_ff[1];
            y_ff[1] <= y_ff[2]; y_ff[2] <= y_ff[1];
            c_ff[1] <= c_ff[2]; c_ff[2] <= c_ff[1];
            area_ff <= -area_raw;
         end else area_ff <= area_raw;
         mnx_ff <= (x_ff[0] < x_ff[1]) ? ((x_ff[0] < x_ff[2]) ? x_ff[0] : x_ff[2])
                                       : ((x_ff[1] < x_ff[2]) ? x_ff[1] : x_ff[2]);
         mxx_ff <= (x_ff[0] > x_ff[1]) ? ((x_ff[0] > x_ff[2]) ? x_ff[0] : x_ff[2])
                                       : ((x_ff[1] > x_ff[2]) ? x_ff[1] : x_ff[2]);
         mny_ff <= (y_ff[0] < y_ff[1]) ? ((y_ff[0] < y_ff[2]) ? y_ff[0] : y_ff[2])
                                       : ((y_ff[1] < y_ff[2]) ? y_ff[1] : y_ff[2]);
         mxy_ff <= (y_ff[0] > y_ff[1]) ? ((y_ff[0] > y_ff[2]) ? y_ff[0] : y_ff[2])
                                       : ((y_ff[1] > y_ff[2]) ? y_ff[1] : y_ff[2]);
      end
      if (cmd.eval) begin
         w_ff[0] <= w_in[0]; w_ff[1] <= w_in[1]; w_ff[2] <= w_in[2];
         col_ff <= '0;
      end
      if (ddone) begin
         if (quot > SW'(ChMax))
            col_ff <= col_ff | (CW'(ChMax) << (chan * CHANNEL_BITS));
         else
            col_ff <= col_ff | (CW'(quot[CHANNEL_BITS-1:0]) << (chan * CHANNEL_BITS));
      end
   end

   // walk position and walk flag; the first eval after a load seeds the corner
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0; wx_ff <= '0; wy_ff <= '0;
      end else if (cmd.load) begin
         walk_ff <= 1'b0;
      end else if (cmd.eval && !walk_ff) begin
         wx_ff <= mnx_ff; wy_ff <= mny_ff; walk_ff <= 1'b1;
      end else if (cmd.advance) begin
         if ({1'b0, wy_ff} + 10'd1 < {1'b0, mxy_ff}) begin
            wy_ff <= wy_ff + YW'(1);
         end else begin
            wy_ff <= mny_ff;
            if ({1'b0, wx_ff} + 11'd1 < {1'b0, mxx_ff}) wx_ff <= wx_ff + XW'(1);
            else walk_ff <= 1'b0;
         end
      end
   end

   assign sts.walking  = (mnx_ff < mxx_ff) && (mny_ff < mxy_ff);
   assign sts.cov      = (area_ff > 0) && pass[0] && pass[1] && pass[2];
   assign sts.div_done = ddone;
   assign sts.last     = !({1'b0, wy_ff} + 10'd1 < {1'b0, mxy_ff})
                         && !({1'b0, wx_ff} + 11'd1 < {1'b0, mxx_ff});
   assign px    = wx_ff;
   assign py    = wy_ff;
   assign color = col_ff;
endmodule

[rtl/gtr_ctrl.sv]
module gtr_ctrl
   import gtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       op,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic [1:0] chan,
   output logic       busy,
   output logic       rsp_valid,
   output logic       rsp_covered,
   output logic       rsp_pos,
   output logic       rsp_done
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SETUP  = 7'b0000010,
      S_EVAL   = 7'b0000100,
      S_COV    = 7'b0001000,
      S_LAUNCH = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type  st_ff, st_in;
   logic       pend_ff, pend_in;   // a walk is pending
   logic       first_ff, first_in; // first tick of a walk: seed position
   logic [1:0] ch_ff, ch_in;

   always_comb begin
      st_in = st_ff; pend_in = pend_ff; first_in = first_ff; ch_in = ch_ff;
      cmd = '0;
      rsp_valid = 1'b0; rsp_covered = 1'b0; rsp_pos = 1'b0; rsp_done = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               if (op == OP_LOAD) begin
                  cmd.load = 1'b1; st_in = S_SETUP;
                  pend_in = 1'b0; ch_in = 2'd0;
               end else if (pend_ff) begin
                  st_in = S_EVAL;
               end else begin
                  rsp_valid = 1'b1; rsp_done = 1'b1;
               end
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1; st_in = S_OUT; first_in = 1'b1;
         end
         S_EVAL: begin
            // first visit seeds the position from the box corner
            cmd.eval = 1'b1;
            if (first_ff) begin
               first_in = 1'b0; st_in = S_EVAL;
            end else st_in = S_COV;
         end
         S_COV: begin
            if (sts.cov) begin
               ch_in = 2'd0; st_in = S_LAUNCH;
            end else begin
               rsp_valid = 1'b1; rsp_pos = 1'b1;
               rsp_done = sts.last; pend_in = !sts.last;
               cmd.advance = 1'b1; st_in = S_IDLE;
            end
         end
         S_LAUNCH: begin
            // channel select is settled: start its division
            cmd.div_go = 1'b1; st_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (ch_ff == 2'd2) st_in = S_OUT;
               else begin
                  ch_in = ch_ff + 2'd1; st_in = S_LAUNCH;
               end
            end
         end
         S_OUT: begin
            if (first_ff && !pend_ff && ch_ff != 2'd3) begin
               // load result
               rsp_valid = 1'b1; rsp_done = !sts.walking;
               pend_in = sts.walking; st_in = S_IDLE; ch_in = 2'd3;
            end else begin
               rsp_valid = 1'b1; rsp_pos = 1'b1; rsp_covered = 1'b1;
               rsp_done = sts.last; pend_in = !sts.last;
               cmd.advance = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pend_ff <= 1'b0; first_ff <= 1'b0; ch_ff <= 2'd0;
      end else begin
         st_ff <= st_in; pend_ff <= pend_in; first_ff <= first_in; ch_ff <= ch_in;
      end
   end

   assign chan = ch_ff;
   assign busy = (st_ff != S_IDLE);
endmodule
